>>> src/rgr_pkg.sv
// ----------------------------------------------------------------------------
// rgr_pkg: shared types and constants of the group reverse reorder buffer
// Register map, reset values and the control structs passed between the
// front, the command queue and the back.
// ----------------------------------------------------------------------------
package rgr_pkg;

	// Default sizes, overridable on the top level
	localparam int MAX_GROUP_DEF  = 16;
	localparam int VALUE_BITS_DEF = 32;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int CFG_W      = 5;

	// Register indexes (byte address / 4)
	localparam logic REG_GROUP_SIZE = 1'b0;

	localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd1;

	// Drain command flags: which bank, reversed or in arrival order, end of sequence
	typedef struct packed {
		logic bank;
		logic rev;
		logic fin;
	} cmd_flags_t;

	// Bank handed back by the back part once its last entry has been read
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

endpackage

>>> src/rgr_item_if.sv
// ----------------------------------------------------------------------------
// rgr_item_if: input request channel
// Valid/ready channel that carries one sequence element and its end flag.
// ----------------------------------------------------------------------------
interface rgr_item_if import rgr_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic                  final_item;

	modport source (output valid, output value, output final_item, input ready);
	modport sink (input valid, input value, input final_item, output ready);
endinterface

>>> src/rgr_result_if.sv
// ----------------------------------------------------------------------------
// rgr_result_if: result request channel
// Valid/ready channel that carries one reordered element and its flags.
// ----------------------------------------------------------------------------
interface rgr_result_if import rgr_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] out_value;
	logic                  run_last;
	logic                  sequence_end;

	modport source (output valid, output out_value, output run_last, output sequence_end,
		input ready);
	modport sink (input valid, input out_value, input run_last, input sequence_end,
		output ready);
endinterface

>>> src/group_reverse_reorder_buffer.sv
// ----------------------------------------------------------------------------
// group_reverse_reorder_buffer: group-wise reversing stream reorderer
// The first result of a group leaves via the command queue and the RAM read
// register once the item that closes the group is accepted. Throughput: one
// item per cycle in, one result per cycle out while results.ready is high; two
// group store banks ping-pong, so input stalls only when both wait to drain.
// Reset: arst_n clears fill count, banks, queue and output valid and sets
// group_size to 1; group store contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
module group_reverse_reorder_buffer import rgr_pkg::*; #(
	parameter int MAX_GROUP  = MAX_GROUP_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	rgr_item_if.sink              items,
	rgr_result_if.source          results
);

	localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CNT_W     = $clog2(MAX_GROUP + 1);
	localparam int AW        = IDX_W + 1;
	localparam int RAM_DEPTH = 2 ** AW;

	// Configuration register
	logic [CFG_W-1:0] group_size_q;
	logic             reg_idx;
	logic             cfg_wr;

	// Front to RAM and queue
	logic                  wr_en;
	logic [AW-1:0]         waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic                  push;
	cmd_flags_t            push_flags;
	logic [CNT_W-1:0]      push_count;
	logic                  q_not_full;

	// Queue and RAM to back
	logic             q_not_empty;
	cmd_flags_t       head_flags;
	logic [CNT_W-1:0] head_count;
	logic             pop;
	bank_rel_t        rel;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic [VALUE_BITS-1:0] rdata;

	// ------------------------------------------------------------------
	// APB register port: zero-wait writes, one register at offset 0.
	// Only the low five bits of the write data are kept.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_RESET;
		end else if (cfg_wr && (reg_idx == REG_GROUP_SIZE)) begin
			group_size_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_GROUP_SIZE) begin
			prdata = APB_DATA_W'(group_size_q);
		end
	end

	// ------------------------------------------------------------------
	// Front: fill one bank with the incoming elements; on a complete
	// group (or end of sequence) queue a drain command for that bank
	// and switch to the other one.
	// ------------------------------------------------------------------
	rgr_front #(
		.MAX_GROUP (MAX_GROUP),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.group_size(group_size_q),
		.rel       (rel),
		.q_not_full(q_not_full),
		.wr_en     (wr_en),
		.waddr     (waddr),
		.wdata     (wdata),
		.push      (push),
		.push_flags(push_flags),
		.push_count(push_count)
	);

	// ------------------------------------------------------------------
	// Group store: two banks of 2**IDX_W entries, bank bit on top. The front
	// writes only a bank that the back has released, so a write never meets a
	// read of the same entry.
	// ------------------------------------------------------------------
	rgr_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// ------------------------------------------------------------------
	// Drain commands in order of completion; two entries cover both banks.
	// ------------------------------------------------------------------
	rgr_cmd_queue #(
		.CNT_W(CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_flags(push_flags),
		.push_count(push_count),
		.pop       (pop),
		.not_empty (q_not_empty),
		.not_full  (q_not_full),
		.head_flags(head_flags),
		.head_count(head_count)
	);

	// ------------------------------------------------------------------
	// Back: read the bank one entry per cycle while the result side accepts; the
	// RAM read register is the output register and holds under backpressure.
	// ------------------------------------------------------------------
	rgr_back #(
		.MAX_GROUP (MAX_GROUP),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_not_empty),
		.head_flags(head_flags),
		.head_count(head_count),
		.pop       (pop),
		.rel       (rel),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata),
		.results   (results)
	);

endmodule

>>> src/rgr_ram.sv
// ----------------------------------------------------------------------------
// rgr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module rgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold read data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/rgr_front.sv
// ----------------------------------------------------------------------------
// rgr_front: intake side of the reorder buffer
// Write each element into the filling bank and issue a drain command when
// the group is complete or the sequence ends.
// ----------------------------------------------------------------------------
module rgr_front import rgr_pkg::*; #(
	parameter int MAX_GROUP  = MAX_GROUP_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
	localparam int CNT_W     = $clog2(MAX_GROUP + 1),
	localparam int AW        = IDX_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rgr_item_if.sink              items,
	input  logic [CFG_W-1:0]      group_size,
	input  bank_rel_t             rel,
	input  logic                  q_not_full,
	output logic                  wr_en,
	output logic [AW-1:0]         waddr,
	output logic [VALUE_BITS-1:0] wdata,
	output logic                  push,
	output cmd_flags_t            push_flags,
	output logic [CNT_W-1:0]      push_count
);

	localparam int KW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CNT_W-1:0] fill_q;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic [1:0]       busy_nxt;
	logic [KW-1:0]    k_eff;
	logic [KW-1:0]    n_ext;
	logic             full_grp;
	logic             accept;

	// clamp the group size to 1..MAX_GROUP
	always_comb begin
		k_eff = KW'(group_size);
		if (k_eff == '0) begin
			k_eff = KW'(1);
		end
		if (k_eff > KW'(MAX_GROUP)) begin
			k_eff = KW'(MAX_GROUP);
		end
	end

	assign n_ext    = KW'(fill_q) + KW'(1);
	assign full_grp = (n_ext >= k_eff);

	// stall while the filling bank is still being drained
	assign items.ready = !busy_q[bank_q] && q_not_full;
	assign accept      = items.valid && items.ready;

	assign wr_en = accept;
	assign waddr = {bank_q, fill_q[IDX_W-1:0]};
	assign wdata = items.value;

	assign push       = accept && (full_grp || items.final_item);
	assign push_count = CNT_W'(n_ext);
	assign push_flags = '{bank: bank_q, rev: full_grp, fin: items.final_item};

	always_comb begin
		busy_nxt = busy_q;
		if (push) begin
			busy_nxt[bank_q] = 1'b1;
		end
		if (rel.valid) begin
			busy_nxt[rel.bank] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_nxt;
			if (accept) begin
				if (push) begin
					fill_q <= '0;
					bank_q <= ~bank_q;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(MAX_GROUP))
		else $error("fill count reached the group store depth");

	a_push_switch: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (fill_q == '0) && (bank_q != $past(bank_q)))
		else $error("drain command did not restart the fill in the other bank");

	a_rel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> busy_q[rel.bank])
		else $error("bank released that was not handed to the back");
`endif

endmodule

>>> src/rgr_cmd_queue.sv
// ----------------------------------------------------------------------------
// rgr_cmd_queue: two-entry drain command queue
// Decouple the front from the back; one entry per bank.
// ----------------------------------------------------------------------------
module rgr_cmd_queue import rgr_pkg::*; #(
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cmd_flags_t       push_flags,
	input  logic [CNT_W-1:0] push_count,
	input  logic             pop,
	output logic             not_empty,
	output logic             not_full,
	output cmd_flags_t       head_flags,
	output logic [CNT_W-1:0] head_count
);

	cmd_flags_t       flags_q [2];
	logic [CNT_W-1:0] count_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       level_q;

	assign not_empty  = (level_q != 2'd0);
	assign not_full   = (level_q != 2'd2);
	assign head_flags = flags_q[rd_ptr_q];
	assign head_count = count_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			flags_q[wr_ptr_q] <= push_flags;
			count_q[wr_ptr_q] <= push_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> not_full) and (pop |-> not_empty))
		else $error("command queue overrun or underrun");
`endif

endmodule

>>> src/rgr_back.sv
// ----------------------------------------------------------------------------
// rgr_back: drain side of the reorder buffer
// Walk one drain command at a time through its bank, reversed or in order,
// and present each element through the RAM read register.
// ----------------------------------------------------------------------------
module rgr_back import rgr_pkg::*; #(
	parameter int MAX_GROUP  = MAX_GROUP_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
	localparam int CNT_W     = $clog2(MAX_GROUP + 1),
	localparam int AW        = IDX_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  cmd_flags_t            head_flags,
	input  logic [CNT_W-1:0]      head_count,
	output logic                  pop,
	output bank_rel_t             rel,
	output logic                  re,
	output logic [AW-1:0]         raddr,
	input  logic [VALUE_BITS-1:0] rdata,
	rgr_result_if.source          results
);

	logic [IDX_W-1:0] idx_q;
	logic             v_s2;
	logic             run_last_s2;
	logic             seq_end_s2;
	logic             advance;
	logic             issue;
	logic             last;
	logic [CNT_W-1:0] rev_idx;
	logic [IDX_W-1:0] rd_idx;

	assign advance = !v_s2 || results.ready;
	assign issue   = head_valid && advance;
	assign last    = ((CNT_W'(idx_q) + CNT_W'(1)) == head_count);
	assign rev_idx = head_count - CNT_W'(1) - CNT_W'(idx_q);
	assign rd_idx  = head_flags.rev ? IDX_W'(rev_idx) : idx_q;

	assign re    = issue;
	assign raddr = {head_flags.bank, rd_idx};
	assign pop   = issue && last;
	assign rel   = '{valid: pop, bank: head_flags.bank};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
			if (advance) begin
				v_s2 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			run_last_s2 <= last;
			seq_end_s2  <= last && head_flags.fin;
		end
	end

	assign results.valid        = v_s2;
	assign results.out_value    = rdata;
	assign results.run_last     = run_last_s2;
	assign results.sequence_end = seq_end_s2;

`ifndef SYNTHESIS
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && seq_end_s2) |-> run_last_s2)
		else $error("sequence end flagged on a result that does not close its run");
`endif

endmodule

>>> tb/rgr_reorder_checker.sv
// ----------------------------------------------------------------------------
// rgr_reorder_checker: predictor and comparator for the reorder buffer
// Tracks the group size register through the configuration port, rebuilds
// each group from accepted item requests and compares every accepted result
// request field by field with the oldest predicted element.
// ----------------------------------------------------------------------------
module rgr_reorder_checker import rgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	rgr_item_if                   items,
	rgr_result_if                 results,
	output int                    pending,
	output int                    checked,
	output int                    errors
);
	localparam int MAX_PRINTS = 30;
	localparam logic [APB_ADDR_W-1:0] GROUP_SIZE_ADDR = APB_ADDR_W'(4 * int'(REG_GROUP_SIZE));

	typedef struct packed {
		logic [VALUE_BITS_DEF-1:0] value;
		logic                      run_last;
		logic                      sequence_end;
	} reordered_t;

	reordered_t                reordered_q[$];
	logic [VALUE_BITS_DEF-1:0] held[MAX_GROUP_DEF];
	int unsigned               held_count;
	logic [CFG_W-1:0]          group_size;

	initial begin
		errors  = 0;
		checked = 0;
	end

	// Clamp the register to the usable range: zero acts as one, saturate at the store depth
	function automatic int unsigned group_limit(logic [CFG_W-1:0] gsize);
		if (gsize == '0)
			return 1;
		if (gsize > MAX_GROUP_DEF)
			return MAX_GROUP_DEF;
		return gsize;
	endfunction

	// Add one element to the held group and queue whatever it releases
	task automatic absorb_element(logic [VALUE_BITS_DEF-1:0] value, logic fin);
		int unsigned k;
		int unsigned n;
		reordered_t  r;
		k = group_limit(group_size);
		held[held_count] = value;
		held_count++;
		n = held_count;
		if (n >= k) begin
			// full group, or size lowered below the fill: newest first
			for (int unsigned i = 0; i < n; i++) begin
				r.value        = held[n - 1 - i];
				r.run_last     = (i + 1 == n);
				r.sequence_end = (i + 1 == n) && fin;
				reordered_q.push_back(r);
			end
			held_count = 0;
		end else if (fin) begin
			// partial group at the end of a sequence: arrival order
			for (int unsigned i = 0; i < n; i++) begin
				r.value        = held[i];
				r.run_last     = (i + 1 == n);
				r.sequence_end = (i + 1 == n);
				reordered_q.push_back(r);
			end
			held_count = 0;
		end
	endtask

	task automatic report_mismatch(string what);
		if (errors < MAX_PRINTS)
			$display("[%0t] reorder check: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reordered_t want;
		if (!arst_n) begin
			reordered_q.delete();
			held_count = 0;
			group_size = GROUP_SIZE_RESET;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == GROUP_SIZE_ADDR) begin
				group_size = pwdata[CFG_W-1:0];
			end
			if (items.valid && items.ready) begin
				absorb_element(items.value, items.final_item);
			end
			if (results.valid && results.ready) begin
				if (reordered_q.size() == 0) begin
					report_mismatch($sformatf("result %h arrived with nothing predicted",
						results.out_value));
				end else begin
					want = reordered_q.pop_front();
					checked++;
					if (results.out_value !== want.value)
						report_mismatch($sformatf("out_value %h, predicted %h",
							results.out_value, want.value));
					if (results.run_last !== want.run_last)
						report_mismatch($sformatf("run_last %b, predicted %b",
							results.run_last, want.run_last));
					if (results.sequence_end !== want.sequence_end)
						report_mismatch($sformatf("sequence_end %b, predicted %b",
							results.sequence_end, want.sequence_end));
				end
			end
			pending <= reordered_q.size();
		end
	end

endmodule

>>> tb/tb_group_reverse_reorder_buffer.sv
// ----------------------------------------------------------------------------
// tb_group_reverse_reorder_buffer: stimulus and verdict for the reorder buffer
// Drives item requests and group size writes, stalls the result side at
// random and leaves prediction and comparison to the checker beside the
// block. A directed opening covers the corner sizes and flush cases; random
// phases follow, each under its own group size.
// ----------------------------------------------------------------------------
module tb_group_reverse_reorder_buffer;
	import rgr_pkg::*;

	localparam int DIRECTED_ITEMS = 24;
	localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + 200;
	// the final stretch of the run goes without random idling on either side
	localparam int QUIET_ITEMS    = 40;
	// a group leaves via the command queue and the RAM read register after its closing request; keep a margin over that
	localparam int SETTLE_CYCLES  = 8;
	localparam logic [APB_ADDR_W-1:0] GROUP_SIZE_ADDR = APB_ADDR_W'(4 * int'(REG_GROUP_SIZE));

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  sink_ready = 1'b0;
	bit                    gaps_on    = 1'b1;
	int                    stall_left = 0;
	int                    pending;
	int                    checked;
	int                    errors;
	int                    sent       = 0;
	int                    sequences  = 0;
	int                    settings   = 0;

	// size schedule of the first ten random phases: extremes mixed with mid values
	logic [CFG_W-1:0] size_plan[10] = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd7, 5'd2,
		5'd12, 5'd5, 5'd4};
	logic [VALUE_BITS_DEF-1:0] corners[4] = '{32'h0000_0000, 32'h8000_0000,
		32'h7FFF_FFFF, 32'hFFFF_FFFF};

	rgr_item_if   items ();
	rgr_result_if results ();

	assign results.ready = sink_ready;

	group_reverse_reorder_buffer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (items),
		.results (results)
	);

	rgr_reorder_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.items   (items),
		.results (results),
		.pending (pending),
		.checked (checked),
		.errors  (errors)
	);

	always #2 clk = ~clk;

	// Result side: stall at random while gaps are on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			sink_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 5);
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// Offer one item request, maybe after an idle burst, and hold it until taken.
	// valid stays high on return so back-to-back requests never drop it.
	task automatic push_request(logic [VALUE_BITS_DEF-1:0] value, logic fin);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		items.valid      <= 1'b1;
		items.value      <= value;
		items.final_item <= fin;
		do @(posedge clk); while (!items.ready);
		sent++;
		if (fin)
			sequences++;
	endtask

	// Drop valid and wait until every predicted result has been seen, then let
	// the pipeline settle; pending is registered in the checker, so poll it only after valid has dropped
	task automatic drain_block();
		items.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup phase, then access phase until pready
	task automatic write_group_size(logic [CFG_W-1:0] gsize);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= GROUP_SIZE_ADDR;
		pwdata  <= APB_DATA_W'(gsize);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings++;
	endtask

	initial begin
		int                        phase;
		int                        left;
		int                        run_len;
		logic [VALUE_BITS_DEF-1:0] pick;

		items.valid      <= 1'b0;
		items.value      <= '0;
		items.final_item <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset size of one: each request passes straight through
		push_request(32'h8000_0000, 1'b0);
		push_request(32'h7FFF_FFFF, 1'b1);
		drain_block();

		// Size zero behaves like one
		write_group_size(5'd0);
		push_request(32'h0000_0000, 1'b1);
		drain_block();

		// Hold three of a group of five, then lower the size to two:
		// the next request flushes all four, newest first
		write_group_size(5'd5);
		for (int i = 0; i < 3; i++)
			push_request(32'hFFFF_FFFF - i, 1'b0);
		drain_block();
		write_group_size(5'd2);
		push_request(32'h0000_0001, 1'b0);
		// a lone request that ends the sequence leaves in arrival order
		push_request(32'h5555_AAAA, 1'b1);
		drain_block();

		// 31 saturates to the full store depth; the final request closes a full group
		write_group_size(5'd31);
		for (int i = 0; i < MAX_GROUP_DEF; i++)
			push_request($urandom, i == MAX_GROUP_DEF - 1);
		drain_block();

		// Random phases: one size per phase, runs of random length. A phase may
		// stop mid-group, so the next size write lands on a partly filled group.
		phase = 0;
		while (sent < TOTAL_ITEMS) begin
			if (sent >= TOTAL_ITEMS - QUIET_ITEMS)
				gaps_on <= 1'b0;
			write_group_size(phase < 10 ? size_plan[phase]
				: CFG_W'($urandom_range(1, MAX_GROUP_DEF)));
			left = $urandom_range(12, 30);
			while (left > 0) begin
				run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40)
					: $urandom_range(1, 16);
				for (int i = 0; i < run_len && left > 0; i++) begin
					pick = ($urandom_range(0, 7) == 0) ? corners[$urandom_range(0, 3)]
						: $urandom;
					push_request(pick, i == run_len - 1);
					left--;
					// hold off mid-phase once until the result side has caught up
					if (phase == 2 && left == 8)
						drain_block();
				end
			end
			drain_block();
			phase++;
		end

		repeat (20) @(posedge clk);
		$display("run: %0d item requests, %0d closed sequences, %0d group size writes",
			sent, sequences, settings);
		$display("run: sizes 0, 1, 16 and 31 included, mid-group size changes, %0d results compared",
			checked);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Fixed ceiling on the run, far above the slowest correct run
	initial begin
		#200000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
src/rgr_pkg.sv
src/rgr_item_if.sv
src/rgr_result_if.sv
src/rgr_ram.sv
src/rgr_front.sv
src/rgr_cmd_queue.sv
src/rgr_back.sv
src/group_reverse_reorder_buffer.sv
tb/rgr_reorder_checker.sv
tb/tb_group_reverse_reorder_buffer.sv
